@@ rtl/core/ple_pkg.sv @@
// Package for the positional list engine.
// Holds the list size, field widths, operation and status codes and the cell command type.
// It has no dependencies.
package ple_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 11;
  localparam int unsigned CmpW  = PosW + 1;
  localparam int unsigned OpW   = 3;
  localparam int unsigned StW   = 2;

  typedef enum logic [OpW-1:0] {
    OpInsFront = 3'd0,
    OpInsEnd   = 3'd1,
    OpInsPos   = 3'd2,
    OpDelFront = 3'd3,
    OpDelEnd   = 3'd4,
    OpDelPos   = 3'd5,
    OpCount    = 3'd6
  } op_e;

  typedef enum logic [StW-1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2,
    StRange = 2'd3
  } status_e;

  typedef struct packed {
    logic            ins;
    logic            del;
    logic [IdxW-1:0] idx;
  } cmd_t;

endpackage

@@ rtl/core/ple_cell.sv @@
// One storage cell of the list chain: holds one entry and shifts with its neighbors.
// Depends on ple_pkg.
module ple_cell import ple_pkg::*; (
  input  logic             clk_i,
  input  logic [IdxW-1:0]  cell_idx_i,
  input  cmd_t             cmd_i,
  input  logic [DataW-1:0] new_value_i,
  input  logic [DataW-1:0] left_i,
  input  logic [DataW-1:0] right_i,
  output logic [DataW-1:0] value_o,
  output logic [DataW-1:0] rd_o
);

  logic [DataW-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    if (cmd_i.ins) begin
      if (cell_idx_i == cmd_i.idx) begin
        value_d = new_value_i;
      end else if (cell_idx_i > cmd_i.idx) begin
        value_d = left_i;
      end
    end else if (cmd_i.del) begin
      if (cell_idx_i >= cmd_i.idx) begin
        value_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign rd_o    = (cell_idx_i == cmd_i.idx) ? value_q : '0;

endmodule

@@ rtl/core/ple_ctrl.sv @@
// Controller of the list engine: keeps the entry count, decodes each operation into a
// cell command and registers the result. Depends on ple_pkg.
module ple_ctrl import ple_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [OpW-1:0]   operation_i,
  input  logic [PosW-1:0]  position_i,
  input  logic [DataW-1:0] rd_data_i,
  output cmd_t             cmd_o,
  output logic             result_valid_o,
  output logic [DataW-1:0] removed_value_o,
  output logic [PosW-1:0]  length_o,
  output logic [StW-1:0]   status_o
);

  logic [CntW-1:0]  count_q, count_d;
  logic             valid_q;
  logic [DataW-1:0] removed_q, removed_d;
  status_e          status_q, status_d;
  logic [CmpW-1:0]  pos_ext, cnt_ext;
  logic             full, empty;
  logic [IdxW-1:0]  pos_idx;

  assign pos_ext = CmpW'(position_i);
  assign cnt_ext = CmpW'(count_q);
  assign full    = (count_q == CntW'(Depth));
  assign empty   = (count_q == '0);
  assign pos_idx = IdxW'(position_i - PosW'(1));

  always_comb begin
    cmd_o     = '0;
    status_d  = StOk;
    removed_d = '0;
    count_d   = count_q;
    case (operation_i)
      OpInsFront, OpInsEnd, OpInsPos: begin
        if (full) begin
          status_d = StFull;
        end else if (operation_i == OpInsFront) begin
          cmd_o.ins = 1'b1;
          cmd_o.idx = '0;
        end else if (operation_i == OpInsEnd) begin
          cmd_o.ins = 1'b1;
          cmd_o.idx = IdxW'(count_q);
        end else if (empty) begin
          cmd_o.ins = 1'b1;
          cmd_o.idx = '0;
        end else if (pos_ext >= CmpW'(1) && pos_ext <= cnt_ext + CmpW'(1)) begin
          cmd_o.ins = 1'b1;
          cmd_o.idx = pos_idx;
        end else begin
          status_d = StRange;
        end
      end
      OpDelFront, OpDelEnd, OpDelPos: begin
        if (empty) begin
          status_d = StEmpty;
        end else if (operation_i == OpDelFront) begin
          cmd_o.del = 1'b1;
          cmd_o.idx = '0;
        end else if (operation_i == OpDelEnd) begin
          cmd_o.del = 1'b1;
          cmd_o.idx = IdxW'(count_q - CntW'(1));
        end else if (pos_ext >= CmpW'(1) && pos_ext <= cnt_ext) begin
          cmd_o.del = 1'b1;
          cmd_o.idx = pos_idx;
        end else begin
          status_d = StRange;
        end
      end
      default: begin
        status_d = StOk;
      end
    endcase
    if (!take_i) begin
      cmd_o.ins = 1'b0;
      cmd_o.del = 1'b0;
    end
    if (cmd_o.ins) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_o.del) begin
      count_d   = count_q - CntW'(1);
      removed_d = rd_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= take_i;
      if (take_i) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      removed_q <= removed_d;
      status_q  <= status_d;
    end
  end

  assign result_valid_o  = valid_q;
  assign removed_value_o = removed_q;
  assign length_o        = PosW'(count_q);
  assign status_o        = status_q;

endmodule

@@ rtl/core/positional_list_engine_top.sv @@
// Top level of the positional list engine: a chain of entry cells and its controller.
// Depends on ple_pkg, ple_cell and ple_ctrl.
//
//   Channel   Handshake                    Fields
//   command   start_i, busy_o              operation_i, value_i, position_i
//   result    result_valid_o (one cycle)   removed_value_o, length_o, status_o
//
// Each command is done in the clock edge that accepts it: the cells at and behind the chosen
// slot shift toward or away from it, and the result is shown in the following cycle.
// busy_o stays low, so a new command may be given in every cycle.
// Reset clears the entry count; the cell contents are left as they are.
// The result is shown for exactly one cycle; the receiver cannot hold it.
module positional_list_engine_top import ple_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [OpW-1:0]          operation_i,
  input  logic signed [DataW-1:0] value_i,
  input  logic [PosW-1:0]         position_i,
  output logic                    result_valid_o,
  output logic signed [DataW-1:0] removed_value_o,
  output logic [PosW-1:0]         length_o,
  output logic [StW-1:0]          status_o
);

  cmd_t             cmd;
  logic             take;
  logic [DataW-1:0] cell_val [Depth];
  logic [DataW-1:0] cell_rd  [Depth];
  logic [DataW-1:0] rd_data;
  logic [DataW-1:0] removed;

  assign busy_o = 1'b0;
  assign take   = start_i & ~busy_o;

  for (genvar k = 0; k < Depth; k++) begin : g_cell
    logic [DataW-1:0] left, right;
    if (k == 0) begin : g_first
      assign left = value_i;
    end else begin : g_mid_l
      assign left = cell_val[k-1];
    end
    if (k == Depth - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_val[k+1];
    end
    ple_cell u_cell (
      .clk_i       (clk_i),
      .cell_idx_i  (IdxW'(k)),
      .cmd_i       (cmd),
      .new_value_i (value_i),
      .left_i      (left),
      .right_i     (right),
      .value_o     (cell_val[k]),
      .rd_o        (cell_rd[k])
    );
  end

  always_comb begin
    rd_data = '0;
    for (int k = 0; k < Depth; k++) begin
      rd_data = rd_data | cell_rd[k];
    end
  end

  ple_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .take_i          (take),
    .operation_i     (operation_i),
    .position_i      (position_i),
    .rd_data_i       (rd_data),
    .cmd_o           (cmd),
    .result_valid_o  (result_valid_o),
    .removed_value_o (removed),
    .length_o        (length_o),
    .status_o        (status_o)
  );

  assign removed_value_o = removed;

endmodule

@@ sim/ple_checker.sv @@
// Checker for the positional list engine: watches the command and result transfers,
// predicts each result from its own copy of the list and compares every field.
// Depends on ple_pkg.
module ple_checker import ple_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    busy_i,
  input  logic [OpW-1:0]          operation_i,
  input  logic signed [DataW-1:0] value_i,
  input  logic [PosW-1:0]         position_i,
  input  logic                    result_valid_i,
  input  logic signed [DataW-1:0] removed_value_i,
  input  logic [PosW-1:0]         length_i,
  input  logic [StW-1:0]          status_i,
  output int unsigned             fail_count_o,
  output int unsigned             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [DataW-1:0] removed;
    logic [PosW-1:0]         length;
    status_e                 status;
  } list_outcome_t;

  logic signed [DataW-1:0] slot_q [Depth];
  int unsigned             entry_total = 0;
  list_outcome_t           outcome_q [$];
  list_outcome_t           want;
  list_outcome_t           next_outcome;
  int unsigned             fail_count = 0;
  int unsigned             result_index = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = outcome_q.size();

  task automatic report_mismatch(input string field, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] exp_val);
    $display("mismatch in result %0d: %s is %0h, predicted %0h",
             result_index, field, got, exp_val);
    fail_count++;
  endtask

  task automatic apply_command(input logic [OpW-1:0] op, input logic signed [DataW-1:0] v,
                               input logic [PosW-1:0] pos, output list_outcome_t res);
    int unsigned slot;
    bit          do_it;
    res   = '{removed: '0, length: '0, status: StOk};
    slot  = 0;
    do_it = 1'b0;
    case (op)
      OpInsFront, OpInsEnd, OpInsPos: begin
        if (entry_total >= Depth) begin
          res.status = StFull;
        end else if (op == OpInsFront) begin
          do_it = 1'b1;
        end else if (op == OpInsEnd) begin
          slot  = entry_total;
          do_it = 1'b1;
        end else if (entry_total == 0) begin
          do_it = 1'b1;
        end else if (pos >= 1 && pos <= entry_total + 1) begin
          slot  = pos - 1;
          do_it = 1'b1;
        end else begin
          res.status = StRange;
        end
        if (do_it) begin
          for (int i = entry_total; i > slot; i--) slot_q[i] = slot_q[i-1];
          slot_q[slot] = v;
          entry_total++;
        end
      end
      OpDelFront, OpDelEnd, OpDelPos: begin
        if (entry_total == 0) begin
          res.status = StEmpty;
        end else if (op == OpDelFront) begin
          do_it = 1'b1;
        end else if (op == OpDelEnd) begin
          slot  = entry_total - 1;
          do_it = 1'b1;
        end else if (pos >= 1 && pos <= entry_total) begin
          slot  = pos - 1;
          do_it = 1'b1;
        end else begin
          res.status = StRange;
        end
        if (do_it) begin
          res.removed = slot_q[slot];
          for (int i = slot; i + 1 < entry_total; i++) slot_q[i] = slot_q[i+1];
          entry_total--;
        end
      end
      default: begin
      end
    endcase
    res.length = PosW'(entry_total);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_total = 0;
      outcome_q.delete();
    end else begin
      if (result_valid_i) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("transfer with no command pending", '0, '0);
        end else begin
          want = outcome_q.pop_front();
          if (removed_value_i !== want.removed) begin
            report_mismatch("removed_value", removed_value_i, want.removed);
          end
          if (length_i !== want.length) begin
            report_mismatch("length", DataW'(length_i), DataW'(want.length));
          end
          if (status_i !== want.status) begin
            report_mismatch("status", DataW'(status_i), DataW'(want.status));
          end
        end
        result_index++;
      end
      if (start_i && !busy_i) begin
        apply_command(operation_i, value_i, position_i, next_outcome);
        outcome_q.push_back(next_outcome);
      end
    end
  end

endmodule

@@ sim/tb_top.sv @@
// Top of the positional list engine testbench: clock, reset and command stimulus.
// Depends on ple_pkg, positional_list_engine_top and ple_checker, which does the checking.
module tb_top;
  import ple_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OpW-1:0] OpSpare   = 3'd7;
  localparam int unsigned RandomItems  = 400;
  localparam int unsigned CycleLimit   = 60000;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    start_i        = 1'b0;
  logic [OpW-1:0]          operation_i    = '0;
  logic signed [DataW-1:0] value_i        = '0;
  logic [PosW-1:0]         position_i     = '0;
  logic                    busy_o;
  logic                    result_valid_o;
  logic signed [DataW-1:0] removed_value_o;
  logic [PosW-1:0]         length_o;
  logic [StW-1:0]          status_o;
  int unsigned             fail_count;
  int unsigned             pending;
  int unsigned             cycle_count    = 0;
  bit                      allow_idle     = 1'b1;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  positional_list_engine_top u_top (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .operation_i,
    .value_i,
    .position_i,
    .result_valid_o,
    .removed_value_o,
    .length_o,
    .status_o
  );

  ple_checker u_checker (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_i          (busy_o),
    .operation_i,
    .value_i,
    .position_i,
    .result_valid_i  (result_valid_o),
    .removed_value_i (removed_value_o),
    .length_i        (length_o),
    .status_i        (status_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_command(input logic [OpW-1:0] op, input logic signed [DataW-1:0] v,
                              input logic [PosW-1:0] pos);
    int unsigned gap;
    gap = allow_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    operation_i <= op;
    value_i     <= v;
    position_i  <= pos;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
  endtask

  function automatic logic [OpW-1:0] pick_op(input int unsigned mode);
    int unsigned roll;
    int unsigned ins_share;
    roll      = $urandom_range(0, 99);
    ins_share = (mode == 0) ? 75 : (mode == 1) ? 20 : 45;
    if (roll < ins_share) begin
      case ($urandom_range(0, 2))
        0:       return OpInsFront;
        1:       return OpInsEnd;
        default: return OpInsPos;
      endcase
    end else if (roll < 92) begin
      case ($urandom_range(0, 2))
        0:       return OpDelFront;
        1:       return OpDelEnd;
        default: return OpDelPos;
      endcase
    end else begin
      return ($urandom_range(0, 1) == 0) ? OpCount : OpSpare;
    end
  endfunction

  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return -32'sd1;
      3:       return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [PosW-1:0] pick_position();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PosW'($urandom_range(Depth + 2, Depth + 4));
      2:       return PosW'($urandom_range(0, (1 << PosW) - 1));
      default: return PosW'($urandom_range(1, Depth + 1));
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned mode;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty list, range errors, extreme values, full list.
    send_command(OpCount, '0, '0);
    send_command(OpDelFront, '0, '0);
    send_command(OpDelEnd, '0, '0);
    send_command(OpDelPos, '0, 11'h7FF);
    send_command(OpInsPos, 32'sh7FFF_FFFF, 11'h7FF);
    send_command(OpInsPos, 32'sd5, 11'd0);
    send_command(OpInsPos, 32'sd6, 11'd3);
    send_command(OpDelPos, '0, 11'd0);
    send_command(OpDelPos, '0, 11'd2);
    send_command(OpInsFront, 32'sh8000_0000, '0);
    send_command(OpInsEnd, -32'sd1, '0);
    send_command(OpInsPos, 32'sd0, 11'd4);
    send_command(OpInsPos, 32'sh5555_AAAA, 11'd1);
    send_command(OpSpare, '0, '0);
    for (int i = 0; i < Depth - 4; i++) begin
      send_command(OpW'(pick_op(0) % 3), $urandom(), PosW'($urandom_range(1, 5)));
    end
    send_command(OpInsFront, 32'sd1, '0);
    send_command(OpInsEnd, 32'sd2, '0);
    send_command(OpInsPos, 32'sd3, 11'd1);
    send_command(OpDelPos, '0, PosW'(Depth));
    send_command(OpDelPos, '0, PosW'(Depth));
    send_command(OpDelFront, '0, '0);
    send_command(OpDelEnd, '0, '0);

    // Random part in bursts that lean toward filling, draining or mixing the list.
    sent = 0;
    while (sent < RandomItems) begin
      burst      = $urandom_range(8, 40);
      mode       = $urandom_range(0, 2);
      allow_idle = ($urandom_range(0, 2) != 0);
      for (int i = 0; i < burst && sent < RandomItems; i++) begin
        send_command(pick_op(mode), pick_value(), pick_position());
        sent++;
      end
    end
    start_i <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
